### rtl/core/res_pkg.sv
package res_pkg;

  localparam int TableDepth = 64;
  localparam int MaxReplicas = 64;
  localparam int ExpTableEntries = 256;
  localparam int ReplicaWidth = 6;
  localparam int CountWidth = 7;
  localparam logic [31:0] Log2eQ22 = 32'd6051102;
  localparam logic [31:0] Ln2Q32 = 32'hB17217F8;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENERGY = 2'd1,
    OP_PAIR   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_MAP,
    ST_WAIT_MAP,
    ST_RD_TAB,
    ST_WAIT_TAB,
    ST_DIFF,
    ST_MAG,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SUM,
    ST_LOG_A,
    ST_LOG_B,
    ST_LOG_SUM,
    ST_TAB_RD,
    ST_INTERP_MUL,
    ST_INTERP_SUB,
    ST_DECIDE,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load_write;
    logic energy_write;
    logic read_start;
    logic pair_start;
    logic rd_map;
    logic rd_tab;
    logic diff;
    logic mag;
    logic mul_lo;
    logic mul_hi;
    logic mul_sum;
    logic log_a;
    logic log_b;
    logic log_sum;
    logic tab_rd;
    logic interp_mul;
    logic interp_sub;
    logic decide;
    logic swap_a;
    logic swap_b;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fast_accept;
    logic out_busy;
  } status_t;

  // 2^(-t) for t in [0,1], Q.32, t in Q.32; evaluated as a constant table
  function automatic logic [63:0] neg_exp2_frac(input logic [63:0] t);
    logic [63:0] u;
    logic [63:0] term;
    logic signed [65:0] sum;
    logic [127:0] prod;
    prod = t * {32'd0, Ln2Q32};
    u = prod[95:32];
    term = 64'h1_0000_0000;
    sum = 66'sh1_0000_0000;
    for (int k = 1; k <= 12; k++) begin
      prod = term * u;
      term = prod[95:32] / 64'(k);
      if (k % 2 == 1) sum = sum - $signed({2'b00, term});
      else sum = sum + $signed({2'b00, term});
    end
    return (sum < 0) ? 64'd0 : sum[63:0];
  endfunction

  function automatic logic [32:0] exp2_entry(input int j, input int entries);
    logic [63:0] t;
    logic [63:0] v;
    t = (64'(j) << 32) / 64'(entries);
    v = neg_exp2_frac(t);
    return v[32:0];
  endfunction

endpackage

### rtl/core/res_ctrl.sv
module res_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      operation,
  input  res_pkg::status_t status,
  output res_pkg::cmd_t   cmd
);

  res_pkg::state_t state;
  res_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= res_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      res_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (operation)
            res_pkg::OP_LOAD: cmd.load_write = 1'b1;
            res_pkg::OP_ENERGY: cmd.energy_write = 1'b1;
            res_pkg::OP_READ: begin
              cmd.read_start = 1'b1;
              state_next = res_pkg::ST_RESULT;
            end
            default: begin
              cmd.pair_start = 1'b1;
              state_next = res_pkg::ST_RD_MAP;
            end
          endcase
        end
      end
      res_pkg::ST_RD_MAP: begin
        cmd.rd_map = 1'b1;
        state_next = res_pkg::ST_WAIT_MAP;
      end
      res_pkg::ST_WAIT_MAP: state_next = res_pkg::ST_RD_TAB;
      res_pkg::ST_RD_TAB: begin
        cmd.rd_tab = 1'b1;
        state_next = res_pkg::ST_WAIT_TAB;
      end
      res_pkg::ST_WAIT_TAB: state_next = res_pkg::ST_DIFF;
      res_pkg::ST_DIFF: begin
        cmd.diff = 1'b1;
        state_next = res_pkg::ST_MAG;
      end
      res_pkg::ST_MAG: begin
        cmd.mag = 1'b1;
        state_next = status.fast_accept ? res_pkg::ST_DECIDE : res_pkg::ST_MUL_LO;
      end
      res_pkg::ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = res_pkg::ST_MUL_HI;
      end
      res_pkg::ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = res_pkg::ST_MUL_SUM;
      end
      res_pkg::ST_MUL_SUM: begin
        cmd.mul_sum = 1'b1;
        state_next = res_pkg::ST_LOG_A;
      end
      res_pkg::ST_LOG_A: begin
        cmd.log_a = 1'b1;
        state_next = res_pkg::ST_LOG_B;
      end
      res_pkg::ST_LOG_B: begin
        cmd.log_b = 1'b1;
        state_next = res_pkg::ST_LOG_SUM;
      end
      res_pkg::ST_LOG_SUM: begin
        cmd.log_sum = 1'b1;
        state_next = res_pkg::ST_TAB_RD;
      end
      res_pkg::ST_TAB_RD: begin
        cmd.tab_rd = 1'b1;
        state_next = res_pkg::ST_INTERP_MUL;
      end
      res_pkg::ST_INTERP_MUL: begin
        cmd.interp_mul = 1'b1;
        state_next = res_pkg::ST_INTERP_SUB;
      end
      res_pkg::ST_INTERP_SUB: begin
        cmd.interp_sub = 1'b1;
        state_next = res_pkg::ST_DECIDE;
      end
      res_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = res_pkg::ST_SWAP_A;
      end
      res_pkg::ST_SWAP_A: begin
        cmd.swap_a = 1'b1;
        state_next = res_pkg::ST_SWAP_B;
      end
      res_pkg::ST_SWAP_B: begin
        cmd.swap_b = 1'b1;
        state_next = res_pkg::ST_RESULT;
      end
      res_pkg::ST_RESULT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = res_pkg::ST_IDLE;
        end
      end
      default: state_next = res_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/core/res_dp.sv
module res_dp #(
  parameter int MAX_REPLICAS = res_pkg::MaxReplicas,
  parameter int EXP_TABLE_ENTRIES = res_pkg::ExpTableEntries
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [6:0]              cfg_data,
  input  logic [1:0]              operation,
  input  logic [5:0]              replica,
  input  logic [31:0]             beta_value,
  input  logic [5:0]              temperature_index,
  input  logic signed [31:0]      energy_value,
  input  logic [31:0]             random_fraction,
  input  logic                    direction,
  input  res_pkg::cmd_t           cmd,
  output res_pkg::status_t        status,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    accepted,
  output logic [5:0]              first_index,
  output logic [5:0]              second_index,
  output logic                    round_done,
  output logic [31:0]             beta_out,
  output logic [5:0]              index_out
);

  localparam int Depth = res_pkg::TableDepth;
  localparam int Limit = (MAX_REPLICAS < Depth) ? MAX_REPLICAS : Depth;
  localparam int JW = $clog2(EXP_TABLE_ENTRIES);

  logic [31:0] beta_mem [Depth];
  logic [5:0]  ior_mem [Depth];
  logic [5:0]  roi_mem [Depth];
  logic [31:0] energy_mem [Depth];

  logic [6:0]  replica_count;
  logic [6:0]  pair_position;
  logic        round_direction;
  logic        is_read;
  logic [31:0] rnd;
  logic [5:0]  pos_i;
  logic [5:0]  pos_n;
  logic        done;
  logic [5:0]  ri;
  logic [5:0]  rn;
  logic [31:0] bi;
  logic [31:0] bn;
  logic [31:0] ei;
  logic [31:0] en;
  logic signed [32:0] db;
  logic signed [32:0] de;
  logic [32:0] mb;
  logic [32:0] me;
  logic        fast;
  logic [63:0] p_lo;
  logic [63:0] p_hi;
  logic [65:0] mag;
  logic        mag_big;
  logic [63:0] l_a;
  logic [63:0] l_b;
  logic [33:0] y;
  logic        kill;
  logic [32:0] ta;
  logic [32:0] tb;
  logic [JW-1:0] jr;
  logic [23:0] rfrac;
  logic [56:0] iprod;
  logic [32:0] ev;
  logic [4:0]  kk;
  logic        acc;
  logic [31:0] rd_beta;
  logic [5:0]  rd_index;

  logic [6:0] n_eff;
  always_comb begin
    if (replica_count < 7'd2) n_eff = 7'd2;
    else if (replica_count > 7'(Limit)) n_eff = 7'(Limit);
    else n_eff = replica_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      replica_count <= 7'd2;
    end else if (cfg_write) begin
      replica_count <= cfg_data;
    end
  end

  logic [6:0] start_pos;
  logic       start_dir;
  logic [6:0] nb_pos;
  logic [6:0] adv;
  always_comb begin
    start_pos = (pair_position >= n_eff) ? 7'd0 : pair_position;
    start_dir = (start_pos == 7'd0) ? direction : round_direction;
    if (start_dir) nb_pos = (start_pos == 7'd0) ? n_eff - 7'd1 : start_pos - 7'd1;
    else nb_pos = (start_pos + 7'd1 >= n_eff) ? 7'd0 : start_pos + 7'd1;
    adv = start_pos + 7'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_position <= '0;
      round_direction <= 1'b0;
    end else if (cmd.pair_start) begin
      round_direction <= start_dir;
      pair_position <= (adv >= n_eff) ? 7'd0 : adv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pair_start) begin
      pos_i <= start_pos[5:0];
      pos_n <= nb_pos[5:0];
      done <= adv >= n_eff;
      rnd <= random_fraction;
      is_read <= 1'b0;
    end
    if (cmd.read_start) begin
      is_read <= 1'b1;
      rd_beta <= beta_mem[replica];
      rd_index <= ior_mem[replica];
    end
  end

  // table writes and reads
  always_ff @(posedge clk) begin
    if (cmd.load_write) begin
      beta_mem[replica] <= beta_value;
      ior_mem[replica] <= temperature_index;
    end else if (cmd.swap_a && acc) begin
      beta_mem[ri] <= bn;
      ior_mem[ri] <= pos_n;
    end else if (cmd.swap_b && acc) begin
      beta_mem[rn] <= bi;
      ior_mem[rn] <= pos_i;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_write) begin
      roi_mem[temperature_index] <= replica;
    end else if (cmd.swap_a && acc) begin
      roi_mem[pos_i] <= rn;
    end else if (cmd.swap_b && acc) begin
      roi_mem[pos_n] <= ri;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.energy_write) begin
      energy_mem[replica] <= energy_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_map) begin
      ri <= roi_mem[pos_i];
      rn <= roi_mem[pos_n];
    end
    if (cmd.rd_tab) begin
      bi <= beta_mem[ri];
      bn <= beta_mem[rn];
      ei <= energy_mem[ri];
      en <= energy_mem[rn];
    end
  end

  // exp table, 2^(-j/N) in Q.32
  logic [32:0] exp_rom [EXP_TABLE_ENTRIES + 1];
  always_comb begin
    for (int j = 0; j <= EXP_TABLE_ENTRIES; j++) begin
      exp_rom[j] = res_pkg::exp2_entry(j, EXP_TABLE_ENTRIES);
    end
  end

  logic [JW:0] jn;
  assign jn = {1'b0, jr} + (JW+1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      db <= $signed({1'b0, bi}) - $signed({1'b0, bn});
      de <= $signed({ei[31], ei}) - $signed({en[31], en});
    end
    if (cmd.mag) begin
      mb <= db[32] ? 33'(-db) : 33'(db);
      me <= de[32] ? 33'(-de) : 33'(de);
      fast <= (db == 0) || (de == 0) || (db[32] == de[32]);
    end
    if (cmd.mul_lo) p_lo <= mb[31:0] * me[31:0];
    if (cmd.mul_hi) p_hi <= (mb[32] ? {31'd0, me} : 64'd0) + (me[32] ? {31'd0, mb[31:0]} : 64'd0);
    if (cmd.mul_sum) mag <= {2'b00, p_lo} + {p_hi[33:0], 32'd0};
    if (cmd.log_a) begin
      mag_big <= mag >= (66'd23 << 36);
      l_a <= mag[31:0] * 32'(res_pkg::Log2eQ22);
    end
    if (cmd.log_b) l_b <= mag[63:32] * 32'(res_pkg::Log2eQ22);
    if (cmd.log_sum) y <= 34'(({l_b, 32'd0} + {32'd0, l_a}) >> 34);
    if (cmd.tab_rd) begin
      kill <= mag_big || (y[33:24] >= 10'd32);
      jr <= y[23:24-JW];
      rfrac <= 24'(y[23:0] << JW);
      kk <= y[28:24];
    end
    if (cmd.interp_mul) begin
      ta <= exp_rom[jr];
      tb <= exp_rom[jn];
      iprod <= (exp_rom[jr] - exp_rom[jn]) * rfrac;
    end
    if (cmd.interp_sub) ev <= (ta - 33'(iprod >> 24)) >> kk;
    if (cmd.decide) acc <= fast || (!kill && ({1'b0, rnd} < ev));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      accepted <= is_read ? 1'b0 : acc;
      first_index <= is_read ? 6'd0 : pos_i;
      second_index <= is_read ? 6'd0 : pos_n;
      round_done <= is_read ? 1'b0 : done;
      beta_out <= is_read ? rd_beta : 32'd0;
      index_out <= is_read ? rd_index : 6'd0;
    end
  end

  assign status.fast_accept = (db == 0) || (de == 0) || (db[32] == de[32]);
  assign status.out_busy = out_valid && out_stall;

  logic unused;
  assign unused = ^{operation, tb, p_hi[63:34], fast};

endmodule

### rtl/core/replica_exchange_swapper_top.sv
// flow: one item at a time; load and energy items do not hold the input, a pair item
// holds it through table reads, split multiply, log, exp lookup (these three skipped
// on fast accept) and the SWAP_A, SWAP_B swap write; read and pair wait out any output stall
// reset: synchronous active-high rst clears the controller, replica_count to 2,
// pair position and direction to 0; replica tables hold undefined data until loaded
module replica_exchange_swapper_top #(
  parameter int MAX_REPLICAS = res_pkg::MaxReplicas,
  parameter int EXP_TABLE_ENTRIES = res_pkg::ExpTableEntries
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [5:0]         replica,
  input  logic [31:0]        beta_value,
  input  logic [5:0]         temperature_index,
  input  logic signed [31:0] energy_value,
  input  logic [31:0]        random_fraction,
  input  logic               direction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               accepted,
  output logic [5:0]         first_index,
  output logic [5:0]         second_index,
  output logic               round_done,
  output logic [31:0]        beta_out,
  output logic [5:0]         index_out
);

  res_pkg::cmd_t    cmd;
  res_pkg::status_t status;

  res_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .status(status), .cmd(cmd)
  );

  res_dp #(
    .MAX_REPLICAS(MAX_REPLICAS), .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .operation(operation), .replica(replica), .beta_value(beta_value),
    .temperature_index(temperature_index), .energy_value(energy_value),
    .random_fraction(random_fraction), .direction(direction),
    .cmd(cmd), .status(status), .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .first_index(first_index), .second_index(second_index),
    .round_done(round_done), .beta_out(beta_out), .index_out(index_out)
  );

endmodule

### tb/tb_replica_exchange_swapper_top.sv
`timescale 1ns / 100ps

module tb_replica_exchange_swapper_top;

  typedef struct packed {
    logic        accepted;
    logic [5:0]  first_index;
    logic [5:0]  second_index;
    logic        round_done;
    logic [31:0] beta_out;
    logic [5:0]  index_out;
  } result_t;

  class swap_scoreboard;
    logic [31:0] beta_of [64];
    logic [5:0]  index_of [64];
    logic [5:0]  replica_at [64];
    logic [31:0] energy_of [64];
    int unsigned position;
    bit          round_dir;
    logic [6:0]  count;
    result_t     pending [$];
    int          errors;
    logic [63:0] exp2_lut [257];

    function new();
      for (int j = 0; j <= 256; j++) exp2_lut[j] = neg_pow2((64'(j) << 32) / 64'd256);
      count = 7'd2;
      position = 0;
      round_dir = 0;
      errors = 0;
    endfunction

    function logic [63:0] neg_pow2(logic [63:0] t);
      logic [127:0] prod;
      logic [63:0] u;
      logic [63:0] term;
      longint sum;
      prod = t * 64'hB17217F8;
      u = prod[95:32];
      term = 64'h1_0000_0000;
      sum = 64'sh1_0000_0000;
      for (int k = 1; k <= 12; k++) begin
        prod = term * u;
        term = prod[95:32] / 64'(k);
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      return (sum < 0) ? 64'd0 : 64'(sum);
    endfunction

    function logic [63:0] exp_of_neg(logic [63:0] mag);
      logic [127:0] prod;
      logic [63:0] y, k, f, p, j, r, a, b, v;
      if (mag >= (64'd23 << 36)) return 64'd0;
      prod = mag * 64'd6051102;
      y = 64'(prod >> 34);
      k = y >> 24;
      f = y & 64'hFFFFFF;
      if (k >= 32) return 64'd0;
      p = f * 64'd256;
      j = p >> 24;
      r = p & 64'hFFFFFF;
      if (j >= 256) j = 255;
      a = exp2_lut[j];
      b = exp2_lut[j + 1];
      v = (a >= b) ? a - (((a - b) * r) >> 24) : a + (((b - a) * r) >> 24);
      return v >> k;
    endfunction

    function void note_input(res_pkg::op_t op, logic [5:0] rep, logic [31:0] beta,
                             logic [5:0] ti, logic [31:0] energy,
                             logic [31:0] rnd, logic dir_in);
      result_t res;
      int unsigned n, i, nb;
      logic [5:0] ri, rn;
      longint db, de;
      logic [63:0] mb, me;
      bit acc, done;
      logic [31:0] tmp;
      res = '0;
      case (op)
        res_pkg::OP_LOAD: begin
          beta_of[rep] = beta;
          index_of[rep] = ti;
          replica_at[ti] = rep;
        end
        res_pkg::OP_ENERGY: energy_of[rep] = energy;
        res_pkg::OP_READ: begin
          res.beta_out = beta_of[rep];
          res.index_out = index_of[rep];
          pending.push_back(res);
        end
        default: begin
          n = (count < 2) ? 2 : (count > 64) ? 64 : count;
          if (position >= n) position = 0;
          if (position == 0) round_dir = dir_in;
          i = position;
          nb = round_dir ? (i + n - 1) % n : (i + 1) % n;
          ri = replica_at[i];
          rn = replica_at[nb];
          db = longint'(beta_of[ri]) - longint'(beta_of[rn]);
          de = longint'($signed(energy_of[ri])) - longint'($signed(energy_of[rn]));
          if (db == 0 || de == 0 || ((db > 0) == (de > 0))) acc = 1;
          else begin
            mb = 64'(db < 0 ? -db : db);
            me = 64'(de < 0 ? -de : de);
            acc = {32'd0, rnd} < exp_of_neg(mb * me);
          end
          if (acc) begin
            index_of[ri] = 6'(nb);
            index_of[rn] = 6'(i);
            replica_at[i] = rn;
            replica_at[nb] = ri;
            tmp = beta_of[ri];
            beta_of[ri] = beta_of[rn];
            beta_of[rn] = tmp;
          end
          position = i + 2;
          done = position >= n;
          if (done) position = 0;
          res.accepted = acc;
          res.first_index = 6'(i);
          res.second_index = 6'(nb);
          res.round_done = done;
          pending.push_back(res);
        end
      endcase
    endfunction

    function void report(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      report("accepted", want.accepted, got.accepted);
      report("first_index", want.first_index, got.first_index);
      report("second_index", want.second_index, got.second_index);
      report("round_done", want.round_done, got.round_done);
      report("beta_out", want.beta_out, got.beta_out);
      report("index_out", want.index_out, got.index_out);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [6:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] operation = '0;
  logic [5:0] replica = '0;
  logic [31:0] beta_value = '0;
  logic [5:0] temperature_index = '0;
  logic signed [31:0] energy_value = '0;
  logic [31:0] random_fraction = '0;
  logic direction = 0;
  logic out_valid;
  logic out_stall = 0;
  logic accepted;
  logic [5:0] first_index;
  logic [5:0] second_index;
  logic round_done;
  logic [31:0] beta_out;
  logic [5:0] index_out;

  swap_scoreboard sb = new();
  bit send_idle = 1;
  bit recv_idle = 1;
  bit recv_hold = 0;
  int quiet_cycles = 0;

  replica_exchange_swapper_top i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .replica(replica), .beta_value(beta_value), .temperature_index(temperature_index),
    .energy_value(energy_value), .random_fraction(random_fraction),
    .direction(direction), .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .first_index(first_index), .second_index(second_index),
    .round_done(round_done), .beta_out(beta_out), .index_out(index_out)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= recv_hold || (recv_idle && $urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({accepted, first_index, second_index, round_done, beta_out, index_out});
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(res_pkg::op_t op, logic [5:0] rep, logic [31:0] beta, logic [5:0] ti,
                      logic [31:0] energy, logic [31:0] rnd, logic dir_in);
    while (send_idle && $urandom_range(99) < 35) begin
      in_valid <= 0;
      @(posedge clk);
    end
    operation <= op;
    replica <= rep;
    beta_value <= beta;
    temperature_index <= ti;
    energy_value <= energy;
    random_fraction <= rnd;
    direction <= dir_in;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, rep, beta, ti, energy, rnd, dir_in);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic set_count(logic [6:0] value);
    cfg_write <= 1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 0;
    sb.count = value;
  endtask

  function automatic logic [31:0] rand_beta();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic logic [31:0] rand_energy();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  task automatic random_item();
    int pick;
    logic [5:0] rep;
    pick = $urandom_range(99);
    rep = 6'($urandom_range(63));
    if (pick < 55)
      send(res_pkg::OP_PAIR, rep, $urandom, 6'($urandom), $urandom, $urandom, 1'($urandom));
    else if (pick < 75)
      send(res_pkg::OP_READ, rep, $urandom, 6'($urandom), $urandom, $urandom, 1'($urandom));
    else if (pick < 92)
      send(res_pkg::OP_ENERGY, rep, $urandom, 6'($urandom), rand_energy(), $urandom,
           1'($urandom));
    else
      send(res_pkg::OP_LOAD, rep, rand_beta(), 6'($urandom), $urandom, $urandom,
           1'($urandom));
  endtask

  initial begin
    logic [5:0] perm [64];
    logic [6:0] counts [10];
    int k;
    logic [5:0] tmp;
    counts = '{7'd2, 7'd64, 7'd3, 7'd0, 7'd127, 7'd1, 7'd5, 7'd40, 7'd17, 7'd64};
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    set_count(7'd64);
    for (int r = 0; r < 64; r++) perm[r] = 6'(r);
    for (int r = 63; r > 0; r--) begin
      k = $urandom_range(r);
      tmp = perm[r];
      perm[r] = perm[k];
      perm[k] = tmp;
    end
    for (int r = 0; r < 64; r++) begin
      send(res_pkg::OP_LOAD, 6'(r), rand_beta(), perm[r], 0, 0, 0);
      send(res_pkg::OP_ENERGY, 6'(r), 0, 0, rand_energy(), 0, 0);
    end

    send(res_pkg::OP_READ, 6'd0, 0, 0, 0, 0, 0);
    send(res_pkg::OP_READ, 6'd63, 0, 0, 0, 0, 0);
    send(res_pkg::OP_LOAD, 6'd0, 32'hFFFFFFFF, sb.index_of[0], 0, 0, 0);
    send(res_pkg::OP_LOAD, 6'd63, 32'h0, sb.index_of[63], 0, 0, 0);
    send(res_pkg::OP_ENERGY, 6'd0, 0, 0, 32'h80000000, 0, 0);
    send(res_pkg::OP_ENERGY, 6'd63, 0, 0, 32'h7FFFFFFF, 0, 0);
    send(res_pkg::OP_READ, 6'd0, 0, 0, 0, 0, 0);
    send(res_pkg::OP_READ, 6'd63, 0, 0, 0, 0, 0);
    send(res_pkg::OP_PAIR, 0, 0, 0, 0, 32'h0, 1'b0);
    send(res_pkg::OP_PAIR, 0, 0, 0, 0, 32'hFFFFFFFF, 1'b1);
    send(res_pkg::OP_PAIR, 0, 0, 0, 0, 32'h80000000, 1'b1);
    drain();
    set_count(7'd4);
    send(res_pkg::OP_ENERGY, sb.replica_at[0], 0, 0, 32'h00000100, 0, 0);
    send(res_pkg::OP_ENERGY, sb.replica_at[3], 0, 0, 32'h00000200, 0, 0);
    send(res_pkg::OP_ENERGY, sb.replica_at[1], 0, 0, 32'hFFFFFF00, 0, 0);
    send(res_pkg::OP_PAIR, 0, 0, 0, 0, 32'h0, 1'b1);
    send(res_pkg::OP_PAIR, 0, 0, 0, 0, 32'hFFFFFFFF, 1'b0);
    send(res_pkg::OP_PAIR, 0, 0, 0, 0, 32'h12345678, 1'b0);
    send(res_pkg::OP_READ, 6'd3, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      set_count(ph == 9 ? 7'($urandom_range(2, 64)) : counts[ph]);
      send_idle = (ph != 2);
      recv_idle = (ph != 2);
      if (ph == 4) begin
        fork
          begin
            recv_hold = 1;
            repeat (400) @(posedge clk);
            recv_hold = 0;
          end
        join_none
      end
      repeat (40) random_item();
    end
    send_idle = 1;
    recv_idle = 1;
    drain();
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

### replica_exchange_swapper_top.f
rtl/core/res_pkg.sv
rtl/core/res_ctrl.sv
rtl/core/res_dp.sv
rtl/core/replica_exchange_swapper_top.sv
tb/tb_replica_exchange_swapper_top.sv
